FILE: hw/rtl/pwl_pkg.sv
// ----------------------------------------------------------------------------
// pwl_pkg
// Types, constants and fixed-point helpers for the word likelihood kernel.
// ----------------------------------------------------------------------------
`default_nettype none

package pwl_pkg;

  localparam int FRAC_BITS = 16;
  localparam int PROB_W    = FRAC_BITS + 1;
  localparam int IDX_W     = 10;
  localparam int OP_W      = 2;
  localparam int CFG_IDX_W = 2;

  localparam logic [PROB_W-1:0] PROB_ONE = PROB_W'(1) << FRAC_BITS;
  localparam logic [PROB_W-1:0] EXISTS_RESET = PROB_W'(25559);
  localparam logic [PROB_W-1:0] ABSENT_RESET = PROB_W'(0);

  localparam logic [OP_W-1:0] OP_WRITE = 2'd0;
  localparam logic [OP_W-1:0] OP_NAIVE = 2'd1;
  localparam logic [OP_W-1:0] OP_TREE  = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_EXISTS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ABSENT = 2'd1;

  typedef struct packed {
    logic [OP_W-1:0]   opcode;
    logic [IDX_W-1:0]  word_index;
    logic [PROB_W-1:0] marginal_prob;
    logic [PROB_W-1:0] cond_prob_parent_on;
    logic [PROB_W-1:0] cond_prob_parent_off;
    logic              word_seen;
    logic              parent_seen;
    logic              place_word_seen;
    logic              new_place;
  } item_t;

  typedef struct packed {
    logic [PROB_W-1:0] likelihood;
    logic              degenerate;
  } result_t;

  typedef struct packed {
    logic [PROB_W-1:0] marg;
    logic [PROB_W-1:0] on;
    logic [PROB_W-1:0] off;
  } entry_t;

  function automatic logic [PROB_W-1:0] sat1(input logic [PROB_W-1:0] v);
    return (v > PROB_ONE) ? PROB_ONE : v;
  endfunction

  function automatic logic [PROB_W-1:0] sel(input logic [PROB_W-1:0] p, input logic b);
    return b ? p : PROB_W'(PROB_ONE - p);
  endfunction

  function automatic logic [PROB_W-1:0] fx_mul(input logic [PROB_W-1:0] a,
                                               input logic [PROB_W-1:0] b);
    logic [2*PROB_W-1:0] p;
    p = (2*PROB_W)'(a) * (2*PROB_W)'(b);
    return p[FRAC_BITS +: PROB_W];
  endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/pwl_div.sv
// ----------------------------------------------------------------------------
// pwl_div
// Pipelined restoring divider, (num << FRAC_BITS) / den, one quotient bit per
// stage. Requires num <= den. Zero den gives 0 and raises zero_den.
// ----------------------------------------------------------------------------
`default_nettype none

module pwl_div #(
  parameter int TAG_W = 8
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      ce,
  input  wire logic                      src_valid,
  input  wire logic [TAG_W-1:0]          src_tag,
  input  wire logic [pwl_pkg::PROB_W-1:0] num,
  input  wire logic [pwl_pkg::PROB_W:0]   den,
  output logic                           res_valid,
  output logic [TAG_W-1:0]               res_tag,
  output logic [pwl_pkg::PROB_W-1:0]     quot,
  output logic                           zero_den
);
  import pwl_pkg::*;

  localparam int STAGES = PROB_W;
  localparam int DW     = PROB_W + 1;

  logic [DW-1:0]     rem_s [STAGES];
  logic [DW-1:0]     den_s [STAGES];
  logic [PROB_W-1:0] q_s   [STAGES];
  logic [TAG_W-1:0]  tag_s [STAGES];
  logic              dz_s  [STAGES];
  logic              v_s   [STAGES];

  for (genvar k = 0; k < STAGES; k++) begin : g_stage
    logic [DW-1:0]     r_prev;
    logic [DW-1:0]     d_prev;
    logic [PROB_W-1:0] q_prev;
    logic [TAG_W-1:0]  t_prev;
    logic              z_prev;
    logic              v_prev;
    logic [DW:0]       trial;
    logic              ge;

    if (k == 0) begin : g_first
      assign r_prev = DW'(num);
      assign d_prev = den;
      assign q_prev = '0;
      assign t_prev = src_tag;
      assign z_prev = (den == '0);
      assign v_prev = src_valid;
      assign trial  = {1'b0, r_prev};
    end else begin : g_next
      assign r_prev = rem_s[k-1];
      assign d_prev = den_s[k-1];
      assign q_prev = q_s[k-1];
      assign t_prev = tag_s[k-1];
      assign z_prev = dz_s[k-1];
      assign v_prev = v_s[k-1];
      assign trial  = {r_prev, 1'b0};
    end

    assign ge = (trial >= {1'b0, d_prev});

    always_ff @(posedge clk) begin
      if (ce) begin
        rem_s[k] <= ge ? DW'(trial - {1'b0, d_prev}) : trial[DW-1:0];
        den_s[k] <= d_prev;
        q_s[k]   <= q_prev | (PROB_W'(ge) << (STAGES - 1 - k));
        tag_s[k] <= t_prev;
        dz_s[k]  <= z_prev;
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        v_s[k] <= 1'b0;
      end else if (ce) begin
        v_s[k] <= v_prev;
      end
    end
  end

  assign res_valid = v_s[STAGES-1];
  assign res_tag   = tag_s[STAGES-1];
  assign zero_den  = dz_s[STAGES-1];
  assign quot      = dz_s[STAGES-1] ? '0 : q_s[STAGES-1];

endmodule

`default_nettype wire

FILE: hw/rtl/place_word_likelihood.sv
// ----------------------------------------------------------------------------
// place_word_likelihood
// Per-word observation likelihood terms (naive and tree) from a word table.
// ----------------------------------------------------------------------------
// channel  handshake            payload
// item     item_valid/stall     item_t: opcode, index, probabilities, bits
// result   result_valid/stall   result_t: likelihood, degenerate
// cfg      cfg_valid/ready      cfg_index, cfg_data
//
// One item per cycle while item_stall is low. After the table read: two multiply
// stages, a bit-per-stage divider, a third multiply stage, two parallel dividers.
// Table writes take effect for an item accepted the next cycle. Synchronous reset
// clears the valid bits and loads the config registers; the table is undefined
// until written. The pipeline holds only when its last stage has a result and
// the output register is full and stalled.
`default_nettype none

module place_word_likelihood #(
  parameter int VOCAB_WORDS = 1024
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         item_valid,
  output logic                              item_stall,
  input  wire pwl_pkg::item_t               item,
  output logic                              result_valid,
  input  wire logic                         result_stall,
  output pwl_pkg::result_t                  result,
  input  wire logic                         cfg_valid,
  output logic                              cfg_ready,
  input  wire logic [pwl_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [pwl_pkg::PROB_W-1:0]    cfg_data
);
  import pwl_pkg::*;

  localparam int AW = (VOCAB_WORDS > 1) ? $clog2(VOCAB_WORDS) : 1;

  typedef struct packed {
    logic              tree;
    logic              np;
    logic [PROB_W-1:0] marg;
    logic [PROB_W-1:0] sa;
    logic [PROB_W-1:0] se;
    logic [PROB_W-1:0] a0;
    logic [PROB_W-1:0] b0;
    logic [PROB_W-1:0] a1;
    logic [PROB_W-1:0] b1;
  } d1_tag_t;

  typedef struct packed {
    logic              tree;
    logic              flag;
    logic [PROB_W-1:0] p0;
  } d2_tag_t;

  // configuration
  logic [PROB_W-1:0] reg_exists;
  logic [PROB_W-1:0] reg_absent;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      reg_exists <= EXISTS_RESET;
      reg_absent <= ABSENT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_EXISTS: reg_exists <= cfg_data;
        REG_ABSENT: reg_absent <= cfg_data;
        default: ;
      endcase
    end
  end

  logic [PROB_W-1:0] pe_e;
  logic [PROB_W-1:0] pe_a;
  assign pe_e = sat1(reg_exists);
  assign pe_a = sat1(reg_absent);

  // flow control
  logic ce;
  logic v_last;
  logic accept;
  assign ce         = !(v_last && result_valid && result_stall);
  assign item_stall = !ce;
  assign accept     = item_valid && ce;

  // word table
  entry_t          mem [VOCAB_WORDS];
  entry_t          rd;
  logic [AW-1:0]   addr;
  logic            inr;

  assign addr = AW'(item.word_index);
  assign inr  = (32'(item.word_index) < VOCAB_WORDS);

  always_ff @(posedge clk) begin
    if (accept && item.opcode == OP_WRITE && inr) begin
      mem[addr] <= '{marg: sat1(item.marginal_prob),
                     on:   sat1(item.cond_prob_parent_on),
                     off:  sat1(item.cond_prob_parent_off)};
    end
    if (ce) begin
      rd <= mem[addr];
    end
  end

  // stage 1: read data
  logic s1_valid;
  logic s1_tree, s1_inr, s1_zq, s1_zp, s1_lz, s1_np;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (ce) begin
      s1_valid <= accept && (item.opcode == OP_NAIVE || item.opcode == OP_TREE);
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      s1_tree <= (item.opcode == OP_TREE);
      s1_inr  <= inr;
      s1_zq   <= item.word_seen;
      s1_zp   <= item.parent_seen;
      s1_lz   <= item.place_word_seen;
      s1_np   <= item.new_place;
    end
  end

  logic [PROB_W-1:0] marg, pon, poff, cond;
  assign marg = s1_inr ? rd.marg : '0;
  assign pon  = s1_inr ? rd.on   : '0;
  assign poff = s1_inr ? rd.off  : '0;
  assign cond = s1_zp ? pon : poff;

  // stage 2: first products
  logic              m1_valid, m1_tree, m1_np;
  logic [PROB_W-1:0] m1_a, m1_b, m1_x0, m1_y0, m1_x1, m1_y1, m1_cn, m1_cp;
  logic [PROB_W-1:0] m1_marg, m1_sa, m1_se;

  always_ff @(posedge clk) begin
    if (rst) begin
      m1_valid <= 1'b0;
    end else if (ce) begin
      m1_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      m1_tree <= s1_tree;
      m1_np   <= s1_np;
      m1_a    <= fx_mul(sel(pe_e, s1_lz), marg);
      m1_b    <= fx_mul(sel(pe_a, s1_lz), PROB_W'(PROB_ONE - marg));
      m1_x0   <= fx_mul(sel(marg, s1_zq), sel(pe_a, !s1_zq));
      m1_y0   <= fx_mul(sel(marg, !s1_zq), sel(pe_a, s1_zq));
      m1_x1   <= fx_mul(sel(marg, s1_zq), sel(pe_e, !s1_zq));
      m1_y1   <= fx_mul(sel(marg, !s1_zq), sel(pe_e, s1_zq));
      m1_cn   <= sel(cond, !s1_zq);
      m1_cp   <= sel(cond, s1_zq);
      m1_marg <= marg;
      m1_sa   <= sel(pe_a, s1_zq);
      m1_se   <= sel(pe_e, s1_zq);
    end
  end

  // stage 3: second products, posterior operands
  logic              m2_valid;
  logic [PROB_W-1:0] m2_qn;
  logic [PROB_W:0]   m2_qd;
  d1_tag_t           m2_tag;

  always_ff @(posedge clk) begin
    if (rst) begin
      m2_valid <= 1'b0;
    end else if (ce) begin
      m2_valid <= m1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      m2_qn       <= m1_a;
      m2_qd       <= (PROB_W+1)'(m1_a) + (PROB_W+1)'(m1_b);
      m2_tag.tree <= m1_tree;
      m2_tag.np   <= m1_np;
      m2_tag.marg <= m1_marg;
      m2_tag.sa   <= m1_sa;
      m2_tag.se   <= m1_se;
      m2_tag.a0   <= fx_mul(m1_x0, m1_cn);
      m2_tag.b0   <= fx_mul(m1_y0, m1_cp);
      m2_tag.a1   <= fx_mul(m1_x1, m1_cn);
      m2_tag.b1   <= fx_mul(m1_y1, m1_cp);
    end
  end

  // existence posterior
  logic              d1_valid, d1_dz;
  d1_tag_t           d1_tag;
  logic [PROB_W-1:0] d1_q;

  pwl_div #(
    .TAG_W ($bits(d1_tag_t))
  ) u_div_post (
    .clk       (clk),
    .rst       (rst),
    .ce        (ce),
    .src_valid (m2_valid),
    .src_tag   (m2_tag),
    .num       (m2_qn),
    .den       (m2_qd),
    .res_valid (d1_valid),
    .res_tag   (d1_tag),
    .quot      (d1_q),
    .zero_den  (d1_dz)
  );

  logic [PROB_W-1:0] pe0, pe1;
  assign pe1 = d1_tag.np ? d1_tag.marg : d1_q;
  assign pe0 = PROB_W'(PROB_ONE - pe1);

  // stage: weighted products
  logic              m3_valid, m3_tree, m3_flag;
  logic [PROB_W-1:0] m3_p0, m3_p1;
  logic [PROB_W:0]   m3_d0, m3_d1;

  always_ff @(posedge clk) begin
    if (rst) begin
      m3_valid <= 1'b0;
    end else if (ce) begin
      m3_valid <= d1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      m3_tree <= d1_tag.tree;
      m3_flag <= !d1_tag.np && d1_dz;
      m3_p0   <= fx_mul(pe0, d1_tag.tree ? d1_tag.b0 : d1_tag.sa);
      m3_p1   <= fx_mul(pe1, d1_tag.tree ? d1_tag.b1 : d1_tag.se);
      m3_d0   <= (PROB_W+1)'(d1_tag.a0) + (PROB_W+1)'(d1_tag.b0);
      m3_d1   <= (PROB_W+1)'(d1_tag.a1) + (PROB_W+1)'(d1_tag.b1);
    end
  end

  // tree quotients
  d2_tag_t           d2_tag_in, d2_tag;
  logic              d2_valid0, d2_valid1, d2_dz0, d2_dz1;
  logic [PROB_W-1:0] d2_t0, d2_t1, d2_p1;

  assign d2_tag_in = '{tree: m3_tree, flag: m3_flag, p0: m3_p0};

  pwl_div #(
    .TAG_W ($bits(d2_tag_t))
  ) u_div_t0 (
    .clk       (clk),
    .rst       (rst),
    .ce        (ce),
    .src_valid (m3_valid),
    .src_tag   (d2_tag_in),
    .num       (m3_p0),
    .den       (m3_d0),
    .res_valid (d2_valid0),
    .res_tag   (d2_tag),
    .quot      (d2_t0),
    .zero_den  (d2_dz0)
  );

  pwl_div #(
    .TAG_W (PROB_W)
  ) u_div_t1 (
    .clk       (clk),
    .rst       (rst),
    .ce        (ce),
    .src_valid (m3_valid),
    .src_tag   (m3_p1),
    .num       (m3_p1),
    .den       (m3_d1),
    .res_valid (d2_valid1),
    .res_tag   (d2_p1),
    .quot      (d2_t1),
    .zero_den  (d2_dz1)
  );

  assign v_last = d2_valid0 && d2_valid1;

  logic [PROB_W:0]   sum;
  logic [PROB_W-1:0] res_sat;
  logic              res_flag;

  assign sum = d2_tag.tree ? (PROB_W+1)'(d2_t0) + (PROB_W+1)'(d2_t1)
                           : (PROB_W+1)'(d2_tag.p0) + (PROB_W+1)'(d2_p1);
  assign res_sat  = (sum > (PROB_W+1)'(PROB_ONE)) ? PROB_ONE : sum[PROB_W-1:0];
  assign res_flag = d2_tag.flag || (d2_tag.tree && (d2_dz0 || d2_dz1));

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (v_last && ce) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (v_last && ce) begin
      result.likelihood <= res_sat;
      result.degenerate <= res_flag;
    end
  end

endmodule

`default_nettype wire
